>>> design/rcsfe_pkg.sv
// ----------------------------------------------------------------------------
// rcsfe_pkg - shared types and constants of the RC serial frame encoder
// Protocol mode codes, frame kinds, the frame buffer type and channel constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rcsfe_pkg;

	// protocol_mode register codes
	localparam logic [2:0] MODE_PPM  = 3'd1;
	localparam logic [2:0] MODE_IBUS = 3'd2;
	localparam logic [2:0] MODE_SBUS = 3'd3;
	localparam logic [2:0] MODE_CRSF = 3'd4;

	localparam int unsigned MAX_CHANNELS  = 8;
	localparam int unsigned FRAME_BYTES   = 32;
	localparam int unsigned MAP_W         = 11;

	localparam logic [15:0] RAW_CENTER    = 16'd1500;
	localparam logic [10:0] MAPPED_CENTER = 11'd992;

	typedef enum logic [1:0] {
		KIND_IBUS = 2'd0,
		KIND_SBUS = 2'd1,
		KIND_CRSF = 2'd2
	} kind_t;

	typedef logic [MAP_W-1:0] mapped_t;

	typedef struct packed {
		kind_t                    kind;
		logic [FRAME_BYTES-1:0][7:0] data;
	} frame_t;

endpackage

`default_nettype wire

>>> design/rcsfe_lane.sv
// ----------------------------------------------------------------------------
// rcsfe_lane - one channel mapping lane
// Clamps a channel to 1000..2000 us and maps it to the 11-bit serial value
// (v-1500)*8/5+992, truncating toward zero. Result is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsfe_lane (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic [15:0]         channel,
	output rcsfe_pkg::mapped_t       mapped_s1
);

	logic [10:0] clamped;
	logic        neg;
	logic [8:0]  mag;
	logic [11:0] mag8;
	logic [25:0] prod;
	logic [9:0]  quot;
	rcsfe_pkg::mapped_t mapped;

	always_comb begin
		if (channel < 16'd1000) begin
			clamped = 11'd1000;
		end else if (channel > 16'd2000) begin
			clamped = 11'd2000;
		end else begin
			clamped = channel[10:0];
		end
		neg  = clamped < 11'd1500;
		mag  = neg ? 9'(11'd1500 - clamped) : 9'(clamped - 11'd1500);
		mag8 = {mag, 3'b000};
		// divide by 5: x*13108 >> 16 is exact for x <= 4000
		prod = 26'(mag8) * 26'd13108;
		quot = prod[25:16];
		mapped = neg ? (rcsfe_pkg::MAPPED_CENTER - 11'(quot))
		             : (rcsfe_pkg::MAPPED_CENTER + 11'(quot));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mapped_s1 <= mapped;
		end
	end

endmodule

`default_nettype wire

>>> design/rcsfe_merge.sv
// ----------------------------------------------------------------------------
// rcsfe_merge - frame assembly
// Combines lane results (raw values for iBUS) into one frame image
// (header, channel payload, flags) and holds it until the serializer
// takes it. Checksum bytes are left zero; the serializer fills them in on output.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsfe_merge (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire logic [2:0]          mode,
	input  wire logic                failsafe,
	input  wire logic [15:0]         raw [rcsfe_pkg::MAX_CHANNELS],
	input  wire rcsfe_pkg::mapped_t  mapped [rcsfe_pkg::MAX_CHANNELS],
	output      logic                out_valid,
	input  wire logic                out_ready,
	output rcsfe_pkg::frame_t        out_frame
);

	logic [175:0]       packed_ch;
	logic [15:0]        ibus_v;
	logic               emit;
	rcsfe_pkg::frame_t  frame;
	logic               pend_valid_q;
	rcsfe_pkg::frame_t  pend_q;
	logic               in_fire;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			packed_ch[i*11 +: 11] = (i < 8) ? mapped[i[2:0]] : rcsfe_pkg::MAPPED_CENTER;
		end
	end

	always_comb begin
		frame      = '0;
		frame.kind = rcsfe_pkg::KIND_IBUS;
		emit       = 1'b0;
		ibus_v     = rcsfe_pkg::RAW_CENTER;
		unique case (mode)
			rcsfe_pkg::MODE_IBUS: begin
				emit          = !failsafe;
				frame.kind    = rcsfe_pkg::KIND_IBUS;
				frame.data[0] = 8'h20;
				frame.data[1] = 8'h40;
				for (int i = 0; i < 14; i++) begin
					ibus_v = (i < 8) ? raw[i[2:0]] : rcsfe_pkg::RAW_CENTER;
					frame.data[2 + 2*i] = ibus_v[7:0];
					frame.data[3 + 2*i] = ibus_v[15:8];
				end
			end
			rcsfe_pkg::MODE_SBUS: begin
				emit          = 1'b1;
				frame.kind    = rcsfe_pkg::KIND_SBUS;
				frame.data[0] = 8'h0F;
				for (int k = 0; k < 22; k++) begin
					frame.data[1 + k] = packed_ch[k*8 +: 8];
				end
				frame.data[23] = failsafe ? 8'h08 : 8'h00;
			end
			rcsfe_pkg::MODE_CRSF: begin
				emit          = !failsafe;
				frame.kind    = rcsfe_pkg::KIND_CRSF;
				frame.data[0] = 8'hEE;
				frame.data[1] = 8'h18;
				frame.data[2] = 8'h16;
				for (int k = 0; k < 22; k++) begin
					frame.data[3 + k] = packed_ch[k*8 +: 8];
				end
			end
			default: begin
				// PPM and undefined modes send nothing
				emit = 1'b0;
			end
		endcase
	end

	assign in_ready  = !pend_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = pend_valid_q;
	assign out_frame = pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (in_ready) begin
			pend_valid_q <= in_fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			pend_q <= frame;
		end
	end

endmodule

`default_nettype wire

>>> design/rcsfe_serializer.sv
// ----------------------------------------------------------------------------
// rcsfe_serializer - byte output stage
// Shifts a frame out one byte per transfer, keeping the iBUS sum and the
// CRSF CRC-8 (poly 0xD5) running so the check bytes follow without delay.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsfe_serializer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire rcsfe_pkg::frame_t   in_frame,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      logic [7:0]          out_byte,
	output      logic                out_last
);

	logic                       active_q;
	rcsfe_pkg::kind_t           kind_q;
	logic [rcsfe_pkg::FRAME_BYTES-1:0][7:0] shift_q;
	logic [4:0]                 idx_q;
	logic [15:0]                sum_q;
	logic [7:0]                 crc_q;
	logic [4:0]                 last_idx;
	logic                       out_fire;
	logic                       load;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ 8'hD5) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	always_comb begin
		unique case (kind_q)
			rcsfe_pkg::KIND_IBUS: last_idx = 5'd31;
			rcsfe_pkg::KIND_SBUS: last_idx = 5'd24;
			rcsfe_pkg::KIND_CRSF: last_idx = 5'd25;
			default:              last_idx = 5'd31;
		endcase
	end

	always_comb begin
		out_byte = shift_q[0];
		if (kind_q == rcsfe_pkg::KIND_IBUS && idx_q == 5'd30) begin
			out_byte = sum_q[7:0];
		end else if (kind_q == rcsfe_pkg::KIND_IBUS && idx_q == 5'd31) begin
			out_byte = sum_q[15:8];
		end else if (kind_q == rcsfe_pkg::KIND_CRSF && idx_q == 5'd25) begin
			out_byte = crc_q;
		end
	end

	assign out_valid = active_q;
	assign out_last  = idx_q == last_idx;
	assign out_fire  = out_valid && out_ready;
	assign in_ready  = !active_q || (out_fire && out_last);
	assign load      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (in_ready) begin
			active_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= in_frame.kind;
			shift_q <= in_frame.data;
			idx_q   <= '0;
			sum_q   <= 16'hFFFF;
			crc_q   <= '0;
		end else if (out_fire) begin
			shift_q <= shift_q >> 8;
			idx_q   <= idx_q + 5'd1;
			if (idx_q < 5'd30) begin
				sum_q <= sum_q - 16'(shift_q[0]);
			end
			// CRSF CRC covers bytes 2..24
			if (idx_q >= 5'd2 && idx_q <= 5'd24) begin
				crc_q <= crc8_byte(crc_q, shift_q[0]);
			end
		end
	end

endmodule

`default_nettype wire

>>> design/rc_serial_frame_encoder_core.sv
// ----------------------------------------------------------------------------
// rc_serial_frame_encoder_core - RC serial frame encoder (iBUS / SBUS / CRSF)
// One send request with eight channels in, at most one complete frame out as bytes.
// ----------------------------------------------------------------------------
//  channel   direction  transfer                 payload
//  s_axis    in         one send request         tdata: channel_0..7, tuser: failsafe
//  m_axis    out        one frame byte           tdata: frame_byte, tlast: last_byte
//  cfg       in         protocol_mode write      data[2:0]
//
//  With the serializer idle, a frame's first byte is offered on m_axis once the
//  request has passed the lane map, frame assembly and serializer load registers.
//  The serializer sends one byte per cycle while m_axis is ready; frames are 32
//  bytes for iBUS, 25 for SBUS, 26 for CRSF; that byte port sets the request rate.
//  New requests are taken while a frame drains; a stalled m_axis holds its byte.
//  Reset sets protocol_mode to PPM and empties all stages; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_serial_frame_encoder_core #(
	parameter int unsigned INPUT_CHANNELS = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output      logic         s_axis_tready,
	input  wire logic [127:0] s_axis_tdata,   // channel_0 [15:0] .. channel_7 [127:112]
	input  wire logic [0:0]   s_axis_tuser,   // failsafe
	output      logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output      logic [7:0]   m_axis_tdata,   // frame_byte
	output      logic         m_axis_tlast,
	input  wire logic         cfg_valid,
	output      logic         cfg_ready,
	input  wire logic [2:0]   cfg_data
);

	logic [2:0]               mode_q;
	logic                     valid_s1;
	logic [2:0]               mode_s1;
	logic                     failsafe_s1;
	logic [15:0]              raw_s1 [INPUT_CHANNELS];
	rcsfe_pkg::mapped_t       lane_s1 [INPUT_CHANNELS];
	logic [15:0]              raw_all [rcsfe_pkg::MAX_CHANNELS];
	rcsfe_pkg::mapped_t       mapped_all [rcsfe_pkg::MAX_CHANNELS];
	logic                     in_fire;
	logic                     merge_ready;
	logic                     frame_valid;
	logic                     ser_ready;
	rcsfe_pkg::frame_t        frame;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rcsfe_pkg::MODE_PPM;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	assign s_axis_tready = !valid_s1 || merge_ready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_s1     <= mode_q;
			failsafe_s1 <= s_axis_tuser[0];
		end
	end

	for (genvar g = 0; g < INPUT_CHANNELS; g++) begin : g_lane
		always_ff @(posedge clk) begin
			if (in_fire) begin
				raw_s1[g] <= s_axis_tdata[g*16 +: 16];
			end
		end

		rcsfe_lane u_lane (
			.clk       (clk),
			.en        (in_fire),
			.channel   (s_axis_tdata[g*16 +: 16]),
			.mapped_s1 (lane_s1[g])
		);
	end

	// channels without a lane sit at center
	for (genvar g = 0; g < rcsfe_pkg::MAX_CHANNELS; g++) begin : g_pad
		if (g < INPUT_CHANNELS) begin : g_used
			assign raw_all[g]    = raw_s1[g];
			assign mapped_all[g] = lane_s1[g];
		end else begin : g_center
			assign raw_all[g]    = rcsfe_pkg::RAW_CENTER;
			assign mapped_all[g] = rcsfe_pkg::MAPPED_CENTER;
		end
	end

	rcsfe_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (merge_ready),
		.mode      (mode_s1),
		.failsafe  (failsafe_s1),
		.raw       (raw_all),
		.mapped    (mapped_all),
		.out_valid (frame_valid),
		.out_ready (ser_ready),
		.out_frame (frame)
	);

	rcsfe_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (frame_valid),
		.in_ready  (ser_ready),
		.in_frame  (frame),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the RC serial frame encoder core
// Send requests go in on s_axis and each accepted one is turned into the
// byte sequence it should produce. Bytes coming out of m_axis are compared
// with that sequence. Covers PPM, iBUS, SBUS, CRSF and the undefined mode
// codes, with random stalls on both buses.
// ----------------------------------------------------------------------------

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_IN        = 8;
	localparam int SETTLE_CYC  = 16;    // covers the two-stage front end and then some
	localparam int TAIL_CYC    = 32;
	localparam int STALL_LIMIT = 2000;
	localparam int RX_HOLD_CYC = 400;
	localparam int RX_HOLD_AT  = 700;   // bytes seen before the long hold-off
	localparam int DRAIN_AT    = 90;    // requests accepted before the sender waits out the queue
	localparam int MAX_REPORTS = 10;

	// mode codes the package leaves undefined; the core treats them like PPM
	localparam logic [2:0] MODE_UNDEF_0 = 3'd0;
	localparam logic [2:0] MODE_UNDEF_5 = 3'd5;
	localparam logic [2:0] MODE_UNDEF_6 = 3'd6;
	localparam logic [2:0] MODE_UNDEF_7 = 3'd7;

	localparam logic [7:0] IBUS_LEAD0   = 8'h20;
	localparam logic [7:0] IBUS_LEAD1   = 8'h40;
	localparam logic [7:0] SBUS_START   = 8'h0F;
	localparam logic [7:0] SBUS_FS_FLAG = 8'h08;
	localparam logic [7:0] CRSF_ADDR    = 8'hEE;
	localparam logic [7:0] CRSF_LEN     = 8'd24;
	localparam logic [7:0] CRSF_TYPE    = 8'h16;
	localparam logic [7:0] CRC_POLY     = 8'hD5;

	localparam int US_MIN     = 1000;
	localparam int US_MAX     = 2000;
	localparam int US_MID     = 1500;
	localparam int TICKS_MID  = 992;
	localparam int IBUS_CH    = 14;
	localparam int LANES      = 16;
	localparam int LANE_BYTES = 22;

	typedef struct packed {
		logic             fs;
		logic [7:0][15:0] ch;    // ch[0] lands in tdata[15:0]
	} send_req_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} frame_byte_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;   // channel_0 [15:0] .. channel_7 [127:112]
	logic [0:0]   s_axis_tuser = '0;   // failsafe
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [7:0]   m_axis_tdata;        // frame_byte
	logic         m_axis_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_data = '0;

	send_req_t   send_q[$];
	frame_byte_t pending_bytes[$];
	send_req_t   cur_req;
	frame_byte_t want;
	logic [2:0]  cur_mode = rcsfe_pkg::MODE_PPM;

	bit calm = 1'b0;
	bit drain_pause = 1'b0;
	bit rx_hold_done = 1'b0;
	int send_gap = 0;
	int rx_stall = 0;
	int rx_hold = 0;
	int idle_cycles = 0;
	int err_count = 0;
	int reqs_accepted = 0;
	int frames_expected = 0;
	int bytes_seen = 0;
	int mode_writes = 0;

	rc_serial_frame_encoder_core #(
		.INPUT_CHANNELS(N_IN)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	// ---------------- frame prediction ----------------

	function automatic logic [15:0] lane_us(send_req_t r, int c);
		if (c < N_IN)
			return r.ch[c];
		return 16'(US_MID);
	endfunction

	// clamp to 1000..2000 us, then scale; int division truncates toward zero
	function automatic logic [10:0] us_to_ticks(logic [15:0] v);
		int s;
		s = int'(v);
		if (s < US_MIN) s = US_MIN;
		if (s > US_MAX) s = US_MAX;
		s = (s - US_MID) * 8 / 5 + TICKS_MID;
		return s[10:0];
	endfunction

	function automatic logic [LANE_BYTES*8-1:0] pack_lanes(send_req_t r);
		logic [LANE_BYTES*8-1:0] bits;
		int c;
		bits = '0;
		for (c = 0; c < LANES; c++)
			bits[c*11 +: 11] = us_to_ticks(lane_us(r, c));
		return bits;
	endfunction

	task automatic predict_frame(input send_req_t r);
		logic [7:0]              frm [32];
		logic [LANE_BYTES*8-1:0] lanes;
		logic [15:0]             v;
		logic [15:0]             sum;
		logic [7:0]              crc;
		int                      n;
		int                      i;
		int                      k;
		n = 0;
		case (cur_mode)
			rcsfe_pkg::MODE_IBUS: if (!r.fs) begin
				frm[0] = IBUS_LEAD0;
				frm[1] = IBUS_LEAD1;
				for (i = 0; i < IBUS_CH; i++) begin
					v = lane_us(r, i);
					frm[2 + 2*i] = v[7:0];
					frm[3 + 2*i] = v[15:8];
				end
				sum = 16'hFFFF;
				for (i = 0; i < 30; i++)
					sum = sum - 16'(frm[i]);
				frm[30] = sum[7:0];
				frm[31] = sum[15:8];
				n = 32;
			end
			rcsfe_pkg::MODE_SBUS: begin
				lanes = pack_lanes(r);
				frm[0] = SBUS_START;
				for (i = 0; i < LANE_BYTES; i++)
					frm[1 + i] = lanes[i*8 +: 8];
				frm[23] = r.fs ? SBUS_FS_FLAG : 8'h00;
				frm[24] = 8'h00;
				n = 25;
			end
			rcsfe_pkg::MODE_CRSF: if (!r.fs) begin
				lanes = pack_lanes(r);
				frm[0] = CRSF_ADDR;
				frm[1] = CRSF_LEN;
				frm[2] = CRSF_TYPE;
				for (i = 0; i < LANE_BYTES; i++)
					frm[3 + i] = lanes[i*8 +: 8];
				// CRC-8 over type byte and payload, MSB first
				crc = 8'h00;
				for (i = 2; i < 25; i++) begin
					crc = crc ^ frm[i];
					for (k = 0; k < 8; k++)
						crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
				end
				frm[25] = crc;
				n = 26;
			end
			default: n = 0;
		endcase
		if (n > 0)
			frames_expected++;
		for (i = 0; i < n; i++)
			pending_bytes.push_back('{value: frm[i], last: (i == n - 1)});
	endtask

	task automatic flag_mismatch(input string what, input logic [7:0] exp_v,
		input logic [7:0] got_v);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%0t: %s mismatch: expected %02h, got %02h", $realtime, what, exp_v, got_v);
	endtask

	// ---------------- request stimulus ----------------

	function automatic send_req_t mk_req(input logic [15:0] a, b, c, d, e, f, g, h,
		input logic fs);
		send_req_t r;
		r.ch = {h, g, f, e, d, c, b, a};
		r.fs = fs;
		return r;
	endfunction

	function automatic logic [15:0] edge_us();
		case ($urandom_range(0, 8))
			0: return 16'd0;
			1: return 16'd999;
			2: return 16'd1000;
			3: return 16'd1001;
			4: return 16'd1500;
			5: return 16'd1999;
			6: return 16'd2000;
			7: return 16'd2001;
			default: return 16'hFFFF;
		endcase
	endfunction

	function automatic send_req_t rand_req();
		send_req_t r;
		int c;
		for (c = 0; c < N_IN; c++) begin
			case ($urandom_range(0, 9))
				0: r.ch[c] = 16'($urandom());
				1: r.ch[c] = edge_us();
				default: r.ch[c] = 16'($urandom_range(950, 2050));
			endcase
		end
		r.fs = ($urandom_range(0, 7) == 0);
		return r;
	endfunction

	// ---------------- s_axis driver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_frame(cur_req);
				reqs_accepted++;
				if (reqs_accepted == DRAIN_AT)
					drain_pause = 1'b1;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// offer stands until the transfer
			end else if (drain_pause) begin
				if (pending_bytes.size() == 0)
					drain_pause = 1'b0;
				s_axis_tvalid <= 1'b0;
			end else if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (send_q.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				send_gap = $urandom_range(0, 7);
				s_axis_tvalid <= 1'b0;
			end else begin
				cur_req = send_q.pop_front();
				s_axis_tdata  <= cur_req.ch;
				s_axis_tuser  <= cur_req.fs;
				s_axis_tvalid <= 1'b1;
			end
		end
	end

	// ---------------- m_axis monitor ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				bytes_seen++;
				if (pending_bytes.size() == 0) begin
					flag_mismatch("unexpected byte", 8'h00, m_axis_tdata);
				end else begin
					want = pending_bytes.pop_front();
					if (m_axis_tdata !== want.value)
						flag_mismatch("frame_byte", want.value, m_axis_tdata);
					if (m_axis_tlast !== want.last)
						flag_mismatch("last_byte", 8'(want.last), 8'(m_axis_tlast));
				end
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else if (!rx_hold_done && bytes_seen >= RX_HOLD_AT) begin
				// long back-pressure: the core should fill and stall s_axis
				rx_hold_done = 1'b1;
				rx_hold = RX_HOLD_CYC - 1;
				m_axis_tready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rx_stall = $urandom_range(0, 7);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ---------------- watchdog ----------------

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d bytes still pending",
					$realtime, STALL_LIMIT, pending_bytes.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ---------------- sequence ----------------

	// waits until every request is taken and every frame byte has come back
	task automatic settle();
		while (send_q.size() != 0 || s_axis_tvalid || pending_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_mode(input logic [2:0] m);
		cfg_data  <= m;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_mode = m;
		mode_writes++;
	endtask

	task automatic random_phase(input logic [2:0] m, input int n);
		write_mode(m);
		repeat (n) send_q.push_back(rand_req());
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset mode is PPM: nothing should come out
		send_q.push_back(mk_req(1000, 1200, 1400, 1500, 1600, 1800, 2000, 1500, 1'b0));
		send_q.push_back(mk_req(1500, 1500, 1500, 1500, 1500, 1500, 1500, 1500, 1'b1));
		settle();

		write_mode(rcsfe_pkg::MODE_IBUS);
		send_q.push_back(mk_req(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
		send_q.push_back(mk_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
		send_q.push_back(mk_req(16'hAAAA, 16'h5555, 999, 2001, 1000, 2000, 1500, 65534, 1'b0));
		send_q.push_back(mk_req(1100, 1200, 1300, 1400, 1600, 1700, 1800, 1900, 1'b1));
		settle();

		// clamp edges, and negative offsets where truncation differs from floor
		write_mode(rcsfe_pkg::MODE_SBUS);
		send_q.push_back(mk_req(0, 999, 1000, 1001, 1499, 1501, 1999, 2000, 1'b0));
		send_q.push_back(mk_req(2001, 16'hFFFF, 1500, 1003, 1997, 1234, 1750, 1100, 1'b0));
		send_q.push_back(mk_req(1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 1'b0));
		send_q.push_back(mk_req(2000, 2000, 2000, 2000, 2000, 2000, 2000, 2000, 1'b0));
		send_q.push_back(mk_req(16'h5555, 16'hAAAA, 1002, 1998, 1496, 1504, 0, 16'hFFFF, 1'b1));
		send_q.push_back(mk_req(1500, 1500, 1500, 1500, 1500, 1500, 1500, 1500, 1'b1));
		settle();

		write_mode(rcsfe_pkg::MODE_CRSF);
		send_q.push_back(mk_req(0, 999, 1000, 1001, 1499, 1501, 1999, 2000, 1'b0));
		send_q.push_back(mk_req(2001, 16'hFFFF, 1500, 1003, 1997, 1234, 1750, 1100, 1'b0));
		send_q.push_back(mk_req(1000, 2000, 1000, 2000, 1000, 2000, 1000, 2000, 1'b0));
		send_q.push_back(mk_req(1200, 1300, 1400, 1500, 1600, 1700, 1800, 1900, 1'b1));
		send_q.push_back(mk_req(16'h5555, 16'hAAAA, 1002, 1998, 1496, 1504, 0, 16'hFFFF, 1'b0));
		settle();

		// undefined codes behave like PPM
		write_mode(MODE_UNDEF_0);
		send_q.push_back(mk_req(1500, 1500, 1500, 1500, 1500, 1500, 1500, 1500, 1'b0));
		settle();
		write_mode(MODE_UNDEF_5);
		send_q.push_back(mk_req(1000, 1000, 1000, 1000, 2000, 2000, 2000, 2000, 1'b1));
		settle();
		write_mode(MODE_UNDEF_6);
		send_q.push_back(mk_req(0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
		settle();
		write_mode(MODE_UNDEF_7);
		send_q.push_back(mk_req(1234, 1234, 1234, 1234, 1234, 1234, 1234, 1234, 1'b0));
		settle();

		random_phase(rcsfe_pkg::MODE_IBUS, 45);
		random_phase(rcsfe_pkg::MODE_SBUS, 50);
		random_phase(rcsfe_pkg::MODE_CRSF, 50);
		random_phase(rcsfe_pkg::MODE_PPM, 10);
		random_phase(MODE_UNDEF_7, 3);
		random_phase(MODE_UNDEF_0, 3);

		// closing stretch at full rate on both sides
		calm = 1'b1;
		random_phase(rcsfe_pkg::MODE_SBUS, 25);
		random_phase(rcsfe_pkg::MODE_CRSF, 25);
		repeat (TAIL_CYC) @(posedge clk);

		$display("Checked %0d requests -> %0d frames, %0d bytes, over %0d mode writes",
			reqs_accepted, frames_expected, bytes_seen, mode_writes);
		$display("Modes: PPM, iBUS, SBUS, CRSF and undefined codes; failsafe and clamp edges");
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> rc_serial_frame_encoder_core.f
design/rcsfe_pkg.sv
design/rcsfe_lane.sv
design/rcsfe_merge.sv
design/rcsfe_serializer.sv
design/rc_serial_frame_encoder_core.sv
tb/sv/tb.sv
